[hw/rtl/assert_macros.svh]
// Assertion macros shared by the modular exponentiation RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define MMEX_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define MMEX_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/mmex_pkg.sv]
// Package for the modular exponentiation block: widths, microcode word
// layout, status struct and the microcode program. No dependencies.
package mmex_pkg;

	localparam int MMEX_WIDTH = 32;
	localparam int MMEX_PC_W  = 4;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_IN_IDLE,
		COND_EXP_ZERO,
		COND_MUL_BUSY,
		COND_EBIT_CLR,
		COND_BITS_LEFT,
		COND_OUT_BUSY
	} mmex_cond_t;

	// Multiplicand source
	typedef enum logic [1:0] {
		OPA_ONE,
		OPA_BASE,
		OPA_PROD
	} mmex_opa_t;

	// Multiplier source
	typedef enum logic [1:0] {
		OPX_ONE,
		OPX_BASE,
		OPX_PROD
	} mmex_opx_t;

	typedef struct packed {
		mmex_cond_t             cond;
		logic [MMEX_PC_W-1:0]   target;
		logic                   take;
		logic                   mul_go;
		mmex_opa_t              a_sel;
		mmex_opx_t              x_sel;
		logic                   base_ld;
		logic                   ebit_shift;
		logic                   out_ld;
		logic                   out_one;
	} mmex_uword_t;

	typedef struct packed {
		logic in_valid;
		logic exp_zero;
		logic mul_busy;
		logic ebit;
		logic bits_left;
		logic out_busy;
	} mmex_sts_t;

	localparam logic [MMEX_PC_W-1:0] STEP_WAIT_IN     = 4'd0;
	localparam logic [MMEX_PC_W-1:0] STEP_CHK_EXP     = 4'd1;
	localparam logic [MMEX_PC_W-1:0] STEP_RED_GO      = 4'd2;
	localparam logic [MMEX_PC_W-1:0] STEP_RED_WAIT    = 4'd3;
	localparam logic [MMEX_PC_W-1:0] STEP_ONE_GO      = 4'd4;
	localparam logic [MMEX_PC_W-1:0] STEP_ONE_WAIT    = 4'd5;
	localparam logic [MMEX_PC_W-1:0] STEP_SQR_GO      = 4'd6;
	localparam logic [MMEX_PC_W-1:0] STEP_SQR_WAIT    = 4'd7;
	localparam logic [MMEX_PC_W-1:0] STEP_BIT_TEST    = 4'd8;
	localparam logic [MMEX_PC_W-1:0] STEP_MUL_GO      = 4'd9;
	localparam logic [MMEX_PC_W-1:0] STEP_MUL_WAIT    = 4'd10;
	localparam logic [MMEX_PC_W-1:0] STEP_NEXT_BIT    = 4'd11;
	localparam logic [MMEX_PC_W-1:0] STEP_OUT_PROD    = 4'd12;
	localparam logic [MMEX_PC_W-1:0] STEP_PROD_DONE   = 4'd13;
	localparam logic [MMEX_PC_W-1:0] STEP_OUT_ONE     = 4'd14;
	localparam logic [MMEX_PC_W-1:0] STEP_ONE_DONE    = 4'd15;

	localparam mmex_uword_t UW_NOP = '{
		cond:       COND_NEVER,
		target:     STEP_WAIT_IN,
		take:       1'b0,
		mul_go:     1'b0,
		a_sel:      OPA_ONE,
		x_sel:      OPX_ONE,
		base_ld:    1'b0,
		ebit_shift: 1'b0,
		out_ld:     1'b0,
		out_one:    1'b0
	};

	// Microcode program: jump to target when cond holds, else fall through.
	function automatic mmex_uword_t mmex_rom(input logic [MMEX_PC_W-1:0] pc);
		mmex_uword_t w;
		w = UW_NOP;
		case (pc)
			STEP_WAIT_IN: begin
				w.take   = 1'b1;
				w.cond   = COND_IN_IDLE;
				w.target = STEP_WAIT_IN;
			end
			STEP_CHK_EXP: begin
				w.cond   = COND_EXP_ZERO;
				w.target = STEP_OUT_ONE;
			end
			STEP_RED_GO: begin
				// base mod m as 1 * base
				w.mul_go = 1'b1;
				w.a_sel  = OPA_ONE;
				w.x_sel  = OPX_BASE;
			end
			STEP_RED_WAIT, STEP_ONE_WAIT, STEP_SQR_WAIT, STEP_MUL_WAIT: begin
				w.cond   = COND_MUL_BUSY;
				w.target = pc;
			end
			STEP_ONE_GO: begin
				// keep the reduced base, then form 1 mod m as the start value
				w.base_ld = 1'b1;
				w.mul_go  = 1'b1;
				w.a_sel   = OPA_ONE;
				w.x_sel   = OPX_ONE;
			end
			STEP_SQR_GO: begin
				w.mul_go = 1'b1;
				w.a_sel  = OPA_PROD;
				w.x_sel  = OPX_PROD;
			end
			STEP_BIT_TEST: begin
				w.cond   = COND_EBIT_CLR;
				w.target = STEP_NEXT_BIT;
			end
			STEP_MUL_GO: begin
				w.mul_go = 1'b1;
				w.a_sel  = OPA_BASE;
				w.x_sel  = OPX_PROD;
			end
			STEP_NEXT_BIT: begin
				w.ebit_shift = 1'b1;
				w.cond       = COND_BITS_LEFT;
				w.target     = STEP_SQR_GO;
			end
			STEP_OUT_PROD: begin
				w.out_ld = 1'b1;
				w.cond   = COND_OUT_BUSY;
				w.target = STEP_OUT_PROD;
			end
			STEP_PROD_DONE, STEP_ONE_DONE: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_WAIT_IN;
			end
			STEP_OUT_ONE: begin
				w.out_ld  = 1'b1;
				w.out_one = 1'b1;
				w.cond    = COND_OUT_BUSY;
				w.target  = STEP_OUT_ONE;
			end
			default: begin
				w = UW_NOP;
			end
		endcase
		return w;
	endfunction

endpackage

[hw/rtl/mmex_mulmod.sv]
// Interleaved shift-add modular multiplier, one multiplier bit per cycle.
// Depends on mmex_pkg; a modulus of zero gives the product wrapped at WIDTH bits.
`include "assert_macros.svh"

module mmex_mulmod #(
	parameter int WIDTH = mmex_pkg::MMEX_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [WIDTH-1:0] opa,
	input  logic [WIDTH-1:0] opx,
	input  logic [WIDTH-1:0] modulus,
	output logic             busy,
	output logic [WIDTH-1:0] prod
);
	import mmex_pkg::*;

	localparam int CNT_W = $clog2(WIDTH);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] x_q;

	logic             m_nz;
	logic [WIDTH:0]   m_ext;
	logic [WIDTH:0]   dbl;
	logic [WIDTH:0]   dbl_r;
	logic [WIDTH:0]   sum;
	logic [WIDTH:0]   sum_r;

	always_comb begin
		m_nz  = (modulus != '0);
		m_ext = {1'b0, modulus};
		dbl   = {acc_q, 1'b0};
		if (m_nz && (dbl >= m_ext)) begin
			dbl_r = dbl - m_ext;
		end else begin
			dbl_r = dbl;
		end
		sum = {1'b0, dbl_r[WIDTH-1:0]} + {1'b0, a_q};
		if (x_q[WIDTH-1]) begin
			if (m_nz && (sum >= m_ext)) begin
				sum_r = sum - m_ext;
			end else begin
				sum_r = sum;
			end
		end else begin
			sum_r = {1'b0, dbl_r[WIDTH-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(WIDTH - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= opa;
			x_q   <= opx;
			acc_q <= '0;
		end else if (busy_q) begin
			x_q   <= {x_q[WIDTH-2:0], 1'b0};
			acc_q <= sum_r[WIDTH-1:0];
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

	`MMEX_ASSERT_NXT(a_go_busy, go, busy_q, "multiplier did not start")
	`MMEX_ASSERT_IMP(a_acc_range, busy_q && m_nz, acc_q < modulus, "partial product not reduced")

endmodule

[hw/rtl/mmex_seq.sv]
// Microcode sequencer: step counter, program table lookup, conditional jumps.
// Depends on mmex_pkg for the control word, status struct and program.
`include "assert_macros.svh"

module mmex_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  mmex_pkg::mmex_sts_t sts,
	output mmex_pkg::mmex_uword_t ctl
);
	import mmex_pkg::*;

	logic [MMEX_PC_W-1:0] pc_q;
	logic [MMEX_PC_W-1:0] pc_d;
	mmex_uword_t          uw;
	logic                 jump;

	always_comb begin
		uw = mmex_rom(pc_q);
		case (uw.cond)
			COND_NEVER:     jump = 1'b0;
			COND_ALWAYS:    jump = 1'b1;
			COND_IN_IDLE:   jump = !sts.in_valid;
			COND_EXP_ZERO:  jump = sts.exp_zero;
			COND_MUL_BUSY:  jump = sts.mul_busy;
			COND_EBIT_CLR:  jump = !sts.ebit;
			COND_BITS_LEFT: jump = sts.bits_left;
			COND_OUT_BUSY:  jump = sts.out_busy;
			default:        jump = 1'b0;
		endcase
		pc_d = jump ? uw.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT_IN;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign ctl = uw;

	`MMEX_ASSERT_IMP(a_go_idle, uw.mul_go, !sts.mul_busy, "multiplier started while busy")

endmodule

[hw/rtl/modular_exponentiation.sv]
// Top level of the modular exponentiation block: register port, operand and
// output registers. Depends on mmex_pkg, mmex_seq and mmex_mulmod.
//
//   channel | signals                          | word
//   --------+----------------------------------+------------------
//   in      | in_valid, in_stall, base         | one base value
//   out     | out_valid, out_stall, power_mod  | one result
//   cfg     | psel, penable, pwrite, paddr ... | exponent, modulus
//
// Each modular multiply runs on the one shift-add multiplier; a zero exponent skips
// the multiplies and gives 1. One item is in work at a time; once the result is
// loaded, the sequencer passes a done step and returns to its input step, where the
// next item is accepted. Reset sets exponent to 0 and modulus to 1. A stalled result
// holds the output register and the sequencer waits at its output step.
`include "assert_macros.svh"

module modular_exponentiation #(
	parameter int WIDTH = mmex_pkg::MMEX_WIDTH
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [WIDTH-1:0]                         base,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [WIDTH-1:0]                         power_mod,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [((WIDTH > 32) ? 4 : 3)-1:0]        paddr,
	input  logic [((WIDTH > 32) ? 64 : 32)-1:0]      pwdata,
	output logic [((WIDTH > 32) ? 64 : 32)-1:0]      prdata,
	output logic                                     pready
);
	import mmex_pkg::*;

	localparam int ADDR_W = (WIDTH > 32) ? 4 : 3;
	localparam int DATA_W = (WIDTH > 32) ? 64 : 32;
	localparam int CNT_W  = $clog2(WIDTH);

	logic [WIDTH-1:0] exponent_q;
	logic [WIDTH-1:0] modulus_q;
	logic             cfg_wr;

	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] ebits_q;
	logic [CNT_W-1:0] bit_cnt_q;
	logic             out_valid_q;
	logic [WIDTH-1:0] power_mod_q;

	mmex_sts_t        sts;
	mmex_uword_t      ctl;
	logic             in_acc;
	logic             out_busy;
	logic             out_ld;
	logic             mul_busy;
	logic [WIDTH-1:0] prod;
	logic [WIDTH-1:0] opa;
	logic [WIDTH-1:0] opx;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= '0;
			modulus_q  <= WIDTH'(1);
		end else if (cfg_wr) begin
			if (paddr[ADDR_W-1]) begin
				modulus_q <= pwdata[WIDTH-1:0];
			end else begin
				exponent_q <= pwdata[WIDTH-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[ADDR_W-1]) begin
			prdata = DATA_W'(modulus_q);
		end else begin
			prdata = DATA_W'(exponent_q);
		end
	end

	// sequencer status
	assign in_acc   = in_valid && ctl.take;
	assign in_stall = !ctl.take;
	assign out_busy = out_valid_q && out_stall;
	assign out_ld   = ctl.out_ld && !out_busy;

	always_comb begin
		sts.in_valid  = in_valid;
		sts.exp_zero  = (exponent_q == '0);
		sts.mul_busy  = mul_busy;
		sts.ebit      = ebits_q[WIDTH-1];
		sts.bits_left = (bit_cnt_q != '0);
		sts.out_busy  = out_busy;
	end

	mmex_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	always_comb begin
		case (ctl.a_sel)
			OPA_ONE:  opa = WIDTH'(1);
			OPA_BASE: opa = base_q;
			OPA_PROD: opa = prod;
			default:  opa = WIDTH'(1);
		endcase
		case (ctl.x_sel)
			OPX_ONE:  opx = WIDTH'(1);
			OPX_BASE: opx = base_q;
			OPX_PROD: opx = prod;
			default:  opx = WIDTH'(1);
		endcase
	end

	mmex_mulmod #(
		.WIDTH (WIDTH)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (ctl.mul_go),
		.opa     (opa),
		.opx     (opx),
		.modulus (modulus_q),
		.busy    (mul_busy),
		.prod    (prod)
	);

	// operand registers: take the word, then hold the reduced base and step through the exponent bits
	always_ff @(posedge clk) begin
		if (in_acc) begin
			base_q    <= base;
			ebits_q   <= exponent_q;
			bit_cnt_q <= CNT_W'(WIDTH - 1);
		end else begin
			if (ctl.base_ld) begin
				base_q <= prod;
			end
			if (ctl.ebit_shift) begin
				ebits_q   <= {ebits_q[WIDTH-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			power_mod_q <= ctl.out_one ? WIDTH'(1) : prod;
		end
	end

	assign out_valid = out_valid_q;
	assign power_mod = power_mod_q;

	`MMEX_ASSERT_IMP(a_out_settled, out_ld, !mul_busy, "result loaded while multiply in flight")
	`MMEX_ASSERT_IMP(a_take_idle, in_acc, !mul_busy, "word taken while multiply in flight")

endmodule
